### sv/ttcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcp_pkg
// Shared types, constants and helpers for the triangle transform, cull and
// projection pipeline.
// ----------------------------------------------------------------------------
package ttcp_pkg;

    typedef logic signed [17:0] t_rot;
    typedef logic signed [31:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vert;

    typedef struct packed {
        t_rot   cos_z;
        t_rot   sin_z;
        t_rot   cos_x;
        t_rot   sin_x;
        t_coord x_gain;
        t_coord x_offset;
        t_coord y_gain;
        t_coord y_offset;
    } t_cfg;

    typedef enum logic [2:0] {
        CFG_COS_Z    = 3'd0,
        CFG_SIN_Z    = 3'd1,
        CFG_COS_X    = 3'd2,
        CFG_SIN_X    = 3'd3,
        CFG_X_GAIN   = 3'd4,
        CFG_X_OFFSET = 3'd5,
        CFG_Y_GAIN   = 3'd6,
        CFG_Y_OFFSET = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam t_rot   ROT_ONE  = 18'sd65536;
    localparam t_rot   ROT_ZERO = 18'sd0;
    localparam t_coord GAIN_RST = 32'sd65536;
    localparam t_coord OFS_RST  = 32'sd0;

    // view z bias, 2.5 in Q16.16
    localparam logic signed [38:0] VIEW_Z_OFS = 39'sd163840;

    localparam int XF_LAT   = 4;
    // quotient magnitude is at most 2^62
    localparam int DIV_BITS = 63;
    localparam int PROJ_LAT = DIV_BITS + 3;
    localparam int TOT_LAT  = XF_LAT + PROJ_LAT + 1;

    localparam int SAT_W = 66;

    function automatic t_coord sat32(input logic signed [SAT_W-1:0] v);
        if (v[SAT_W-1:31] == {(SAT_W-31){v[31]}}) begin
            return v[31:0];
        end
        return v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage
`default_nettype wire

### sv/ttcp_xform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcp_xform
// Four-stage vertex rotation: about Z, then about X, then z bias and
// saturation to 32-bit view coordinates.
// ----------------------------------------------------------------------------
module ttcp_xform (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ttcp_pkg::t_vert i_v,
    input  ttcp_pkg::t_cfg  i_cfg,
    output logic            o_valid,
    output ttcp_pkg::t_vert o_v
);
    import ttcp_pkg::*;

    logic [XF_LAT-1:0]  r_vld;
    logic signed [49:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [31:0] r_z1, r_z2;
    logic signed [34:0] r_xr2, r_xr3, r_yr;
    logic signed [52:0] r_p1, r_p3;
    logic signed [49:0] r_p2, r_p4;
    logic signed [50:0] w_xd, w_ysum;
    logic signed [53:0] w_yd, w_zs;
    logic signed [38:0] w_zv;
    t_vert              r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[XF_LAT-2:0], i_valid};
        end
    end

    assign w_xd   = 51'(r_xc) - 51'(r_ys);
    assign w_ysum = 51'(r_xs) + 51'(r_yc);
    assign w_yd   = 54'(r_p1) - 54'(r_p2);
    assign w_zs   = 54'(r_p3) + 54'(r_p4);
    assign w_zv   = 39'($signed(w_zs[53:16])) + VIEW_Z_OFS;

    always_ff @(posedge i_clk) begin
        r_xc  <= i_v.x * i_cfg.cos_z;
        r_ys  <= i_v.y * i_cfg.sin_z;
        r_xs  <= i_v.x * i_cfg.sin_z;
        r_yc  <= i_v.y * i_cfg.cos_z;
        r_z1  <= i_v.z;
        // floor shift: keep the upper bits
        r_xr2 <= w_xd[50:16];
        r_yr  <= w_ysum[50:16];
        r_z2  <= r_z1;
        r_p1  <= r_yr * i_cfg.cos_x;
        r_p2  <= r_z2 * i_cfg.sin_x;
        r_p3  <= r_yr * i_cfg.sin_x;
        r_p4  <= r_z2 * i_cfg.cos_x;
        r_xr3 <= r_xr2;
        r_v.x <= sat32(SAT_W'(r_xr3));
        r_v.y <= sat32(SAT_W'($signed(w_yd[53:16])));
        r_v.z <= sat32(SAT_W'(w_zv));
    end

    assign o_valid = r_vld[XF_LAT-1];
    assign o_v     = r_v;

endmodule
`default_nettype wire

### sv/ttcp_proj.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcp_proj
// Perspective projection of one coordinate: gain * c / z + offset, with a
// fully pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ttcp_proj (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ttcp_pkg::t_coord i_c,
    input  ttcp_pkg::t_coord i_z,
    input  ttcp_pkg::t_coord i_gain,
    input  ttcp_pkg::t_coord i_off,
    output logic             o_valid,
    output ttcp_pkg::t_coord o_s
);
    import ttcp_pkg::*;

    localparam int NB = DIV_BITS;

    logic               r_v1;
    logic signed [63:0] r_prod;
    t_coord             r_z;

    logic               r_vld [0:NB];
    logic [31:0]        r_rem [0:NB];
    logic [NB-1:0]      r_nq  [0:NB];
    logic [31:0]        r_dv  [0:NB];
    logic               r_sg  [0:NB];
    logic               r_zf  [0:NB];
    logic signed [47:0] r_alt [0:NB];

    logic [63:0]              w_mag;
    logic [31:0]              w_dz;
    logic [SAT_W-1:0]         w_qu;
    logic signed [SAT_W-1:0]  w_q, w_pick, w_sum;

    logic   r_vo;
    t_coord r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_vld[0] <= 1'b0;
            r_vo     <= 1'b0;
        end else begin
            r_v1     <= i_valid;
            r_vld[0] <= r_v1;
            r_vo     <= r_vld[NB];
        end
    end

    assign w_mag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
    assign w_dz  = r_z[31] ? 32'(-r_z) : 32'(r_z);

    always_ff @(posedge i_clk) begin
        r_prod   <= i_gain * i_c;
        r_z      <= i_z;
        r_rem[0] <= '0;
        r_nq[0]  <= w_mag[NB-1:0];
        r_dv[0]  <= w_dz;
        r_sg[0]  <= r_prod[63] ^ r_z[31];
        r_zf[0]  <= (r_z == '0);
        r_alt[0] <= r_prod[63:16];
    end

    for (genvar k = 1; k <= NB; k++) begin : g_div
        logic [32:0] w_rs, w_df;
        logic        w_ge;

        assign w_rs = {r_rem[k-1], r_nq[k-1][NB-1]};
        assign w_df = w_rs - {1'b0, r_dv[k-1]};
        assign w_ge = (w_rs >= {1'b0, r_dv[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_df[31:0] : w_rs[31:0];
            r_nq[k]  <= {r_nq[k-1][NB-2:0], w_ge};
            r_dv[k]  <= r_dv[k-1];
            r_sg[k]  <= r_sg[k-1];
            r_zf[k]  <= r_zf[k-1];
            r_alt[k] <= r_alt[k-1];
        end
    end

    // zero view z: plain Q16.16 floor instead of the quotient
    assign w_qu   = SAT_W'(r_nq[NB]);
    assign w_q    = r_sg[NB] ? -$signed(w_qu) : $signed(w_qu);
    assign w_pick = r_zf[NB] ? SAT_W'(r_alt[NB]) : w_q;
    assign w_sum  = w_pick + SAT_W'(i_off);

    always_ff @(posedge i_clk) begin
        r_s <= sat32(w_sum);
    end

    assign o_valid = r_vo;
    assign o_s     = r_s;

endmodule
`default_nettype wire

### sv/ttcp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcp_lane
// One vertex lane: rotation into view space, then x and y projection.
// ----------------------------------------------------------------------------
module ttcp_lane (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ttcp_pkg::t_vert  i_v,
    input  ttcp_pkg::t_cfg   i_cfg,
    output ttcp_pkg::t_vert  o_view,
    output logic             o_valid,
    output ttcp_pkg::t_coord o_sx,
    output ttcp_pkg::t_coord o_sy
);
    import ttcp_pkg::*;

    logic  w_xv, w_pvx, w_pvy;
    t_vert w_view;

    ttcp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_v     (i_v),
        .i_cfg   (i_cfg),
        .o_valid (w_xv),
        .o_v     (w_view)
    );

    ttcp_proj u_proj_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xv),
        .i_c     (w_view.x),
        .i_z     (w_view.z),
        .i_gain  (i_cfg.x_gain),
        .i_off   (i_cfg.x_offset),
        .o_valid (w_pvx),
        .o_s     (o_sx)
    );

    ttcp_proj u_proj_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xv),
        .i_c     (w_view.y),
        .i_z     (w_view.z),
        .i_gain  (i_cfg.y_gain),
        .i_off   (i_cfg.y_offset),
        .o_valid (w_pvy),
        .o_s     (o_sy)
    );

    assign o_view  = w_view;
    assign o_valid = w_pvx & w_pvy;

endmodule
`default_nettype wire

### sv/ttcp_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcp_merge
// Combines the three lanes: sign of V0 . (V1 x V2) for the back-face test
// and the saturated depth key, both delayed to line up with the projections.
// ----------------------------------------------------------------------------
module ttcp_merge (
    input  logic             i_clk,
    input  ttcp_pkg::t_vert  i_v [3],
    output logic             o_keep,
    output ttcp_pkg::t_coord o_depth
);
    import ttcp_pkg::*;

    localparam int KEEP_DLY = PROJ_LAT - 5;
    localparam int DEP_DLY  = PROJ_LAT - 1;
    localparam int DW       = 98;

    t_coord w_a [6];
    t_coord w_b [6];
    t_coord w_c [6];

    logic signed [63:0]   r_ab [6];
    t_coord               r_c  [6];
    logic signed [63:0]   r_ph [6];
    logic signed [64:0]   r_pl [6];
    logic signed [DW-1:0] r_t  [6];
    logic signed [DW-1:0] r_s  [3];
    logic signed [DW-1:0] r_u, r_w, w_d;
    logic signed [33:0]   r_dsum;
    logic                 r_kd [0:KEEP_DLY-1];
    t_coord               r_dd [0:DEP_DLY-1];

    // terms in order +, -, +, -, +, -
    always_comb begin
        w_a[0] = i_v[0].x; w_b[0] = i_v[1].y; w_c[0] = i_v[2].z;
        w_a[1] = i_v[0].x; w_b[1] = i_v[1].z; w_c[1] = i_v[2].y;
        w_a[2] = i_v[0].y; w_b[2] = i_v[1].z; w_c[2] = i_v[2].x;
        w_a[3] = i_v[0].y; w_b[3] = i_v[1].x; w_c[3] = i_v[2].z;
        w_a[4] = i_v[0].z; w_b[4] = i_v[1].x; w_c[4] = i_v[2].y;
        w_a[5] = i_v[0].z; w_b[5] = i_v[1].y; w_c[5] = i_v[2].x;
    end

    assign w_d = r_u + r_w;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r_ab[k] <= w_a[k] * w_b[k];
            r_c[k]  <= w_c[k];
            // 64 x 32 split into partial products on the two 32-bit halves of the 64-bit term
            r_ph[k] <= $signed(r_ab[k][63:32]) * r_c[k];
            r_pl[k] <= $signed({1'b0, r_ab[k][31:0]}) * r_c[k];
            r_t[k]  <= $signed({{2{r_ph[k][63]}}, r_ph[k], 32'b0}) + DW'(r_pl[k]);
        end
        for (int k = 0; k < 3; k++) begin
            r_s[k] <= r_t[2*k] - r_t[2*k+1];
        end
        r_u    <= r_s[0] + r_s[1];
        r_w    <= r_s[2];
        r_dsum <= 34'(i_v[0].z) + 34'(i_v[1].z) + 34'(i_v[2].z);
        r_kd[0] <= w_d[DW-1];
        r_dd[0] <= sat32(SAT_W'(r_dsum));
        for (int i = 1; i < KEEP_DLY; i++) begin
            r_kd[i] <= r_kd[i-1];
        end
        for (int i = 1; i < DEP_DLY; i++) begin
            r_dd[i] <= r_dd[i-1];
        end
    end

    assign o_keep  = r_kd[KEEP_DLY-1];
    assign o_depth = r_dd[DEP_DLY-1];

endmodule
`default_nettype wire

### sv/triangle_transform_cull_project_top.sv
`default_nettype none
// A start flows through xform, projection and the output register to o_valid.
// Throughput: one triangle per cycle; o_busy stays low.
// Most latency is in the 63-stage quotient pipeline in each projection unit.
// Culled triangles produce no strobe. Synchronous active-low reset clears all
// valid flags and loads the identity rotation, unit gains and zero offsets.
// ----------------------------------------------------------------------------
// triangle_transform_cull_project_top
// Three vertex lanes, a merge stage for culling and depth, output register.
// ----------------------------------------------------------------------------
module triangle_transform_cull_project_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic                                   i_cfg_we,
    input  logic [ttcp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ttcp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [31:0]                     i_a_x,
    input  logic signed [31:0]                     i_a_y,
    input  logic signed [31:0]                     i_a_z,
    input  logic signed [31:0]                     i_b_x,
    input  logic signed [31:0]                     i_b_y,
    input  logic signed [31:0]                     i_b_z,
    input  logic signed [31:0]                     i_c_x,
    input  logic signed [31:0]                     i_c_y,
    input  logic signed [31:0]                     i_c_z,
    output logic                                   o_valid,
    output logic signed [31:0]                     o_sa_x,
    output logic signed [31:0]                     o_sa_y,
    output logic signed [31:0]                     o_sb_x,
    output logic signed [31:0]                     o_sb_y,
    output logic signed [31:0]                     o_sc_x,
    output logic signed [31:0]                     o_sc_y,
    output logic signed [31:0]                     o_depth_key
);
    import ttcp_pkg::*;

    t_cfg   r_cfg;
    t_vert  w_in   [3];
    t_vert  w_view [3];
    logic [2:0] w_pv;
    t_coord w_sx [3];
    t_coord w_sy [3];
    logic   w_keep;
    t_coord w_depth;

    logic   r_valid;
    t_coord r_sx [3];
    t_coord r_sy [3];
    t_coord r_depth;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_z    <= ROT_ONE;
            r_cfg.sin_z    <= ROT_ZERO;
            r_cfg.cos_x    <= ROT_ONE;
            r_cfg.sin_x    <= ROT_ZERO;
            r_cfg.x_gain   <= GAIN_RST;
            r_cfg.x_offset <= OFS_RST;
            r_cfg.y_gain   <= GAIN_RST;
            r_cfg.y_offset <= OFS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COS_Z:    r_cfg.cos_z    <= i_cfg_data[17:0];
                CFG_SIN_Z:    r_cfg.sin_z    <= i_cfg_data[17:0];
                CFG_COS_X:    r_cfg.cos_x    <= i_cfg_data[17:0];
                CFG_SIN_X:    r_cfg.sin_x    <= i_cfg_data[17:0];
                CFG_X_GAIN:   r_cfg.x_gain   <= i_cfg_data;
                CFG_X_OFFSET: r_cfg.x_offset <= i_cfg_data;
                CFG_Y_GAIN:   r_cfg.y_gain   <= i_cfg_data;
                CFG_Y_OFFSET: r_cfg.y_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_in[0] = '{x: i_a_x, y: i_a_y, z: i_a_z};
    assign w_in[1] = '{x: i_b_x, y: i_b_y, z: i_b_z};
    assign w_in[2] = '{x: i_c_x, y: i_c_y, z: i_c_z};

    for (genvar g = 0; g < 3; g++) begin : g_lane
        ttcp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (i_start & ~o_busy),
            .i_v     (w_in[g]),
            .i_cfg   (r_cfg),
            .o_view  (w_view[g]),
            .o_valid (w_pv[g]),
            .o_sx    (w_sx[g]),
            .o_sy    (w_sy[g])
        );
    end

    ttcp_merge u_merge (
        .i_clk   (i_clk),
        .i_v     (w_view),
        .o_keep  (w_keep),
        .o_depth (w_depth)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (&w_pv) & w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sx[k] <= w_sx[k];
            r_sy[k] <= w_sy[k];
        end
        r_depth <= w_depth;
    end

    assign o_valid     = r_valid;
    assign o_sa_x      = r_sx[0];
    assign o_sa_y      = r_sy[0];
    assign o_sb_x      = r_sx[1];
    assign o_sb_y      = r_sy[1];
    assign o_sc_x      = r_sx[2];
    assign o_sc_y      = r_sy[2];
    assign o_depth_key = r_depth;

`ifndef NO_ASSERTIONS
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pv[0] == w_pv[1]) && (w_pv[1] == w_pv[2]))
        else $error("vertex lanes out of step");

    a_out_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, TOT_LAT))
        else $error("result strobe without a matching request");
`endif

endmodule
`default_nettype wire
